@@ design/sht_pkg.sv @@
// Package for the segment handle table: beat structs, codes and constants.
// Used by every module of the design; depends on nothing.
`timescale 1ns / 1ps
package sht_pkg;
	localparam int DEFAULT_ENTRIES = 16;
	localparam int CNT_W = 5;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_EVICT = 3'd1;
	localparam logic [2:0] OP_RELOAD = 3'd2;
	localparam logic [2:0] OP_LOCK = 3'd3;
	localparam logic [2:0] OP_UNLOCK = 3'd4;
	localparam logic [2:0] OP_COMPACT = 3'd5;
	localparam logic [2:0] OP_QUERY = 3'd6;
	localparam logic [2:0] OP_RESERVED = 3'd7;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_BAD_HANDLE = 4'd1;
	localparam logic [3:0] ST_NOT_FOUND = 4'd2;
	localparam logic [3:0] ST_NOT_DISC = 4'd3;
	localparam logic [3:0] ST_LOCKED = 4'd4;
	localparam logic [3:0] ST_LOADED = 4'd5;
	localparam logic [3:0] ST_NO_FILE = 4'd6;
	localparam logic [3:0] ST_BOUNDS = 4'd7;
	localparam logic [3:0] ST_FULL = 4'd8;
	localparam logic [3:0] ST_NOT_LOADED = 4'd9;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_FILE_LEN = 2'd1;

	localparam logic [15:0] NE_MOVABLE = 16'h0010;
	localparam logic [15:0] NE_DISC = 16'h1000;

	typedef struct packed {
		logic [2:0] operation;
		logic [15:0] handle;
		logic [15:0] seg_flags;
		logic data_present;
		logic [31:0] seg_alloc;
		logic [31:0] file_offset;
		logic [31:0] file_bytes;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] status;
		logic [15:0] handle_out;
		logic [3:0] state_flags;
		logic [15:0] lock_count_out;
		logic [31:0] alloc_size_out;
		logic [4:0] eligible_count;
	} out_beat_t;

	// One slot descriptor as it travels along the chain.
	typedef struct packed {
		logic [15:0] hdl;
		logic [3:0] flags;
		logic has_data;
		logic [15:0] lock;
		logic [31:0] alloc;
		logic [31:0] foff;
		logic [31:0] fsize;
	} slot_t;

	// Token that visits the cells one per cycle.
	typedef struct packed {
		logic active;
		logic [2:0] op;
		logic [15:0] hdl;
		logic in_cap;
		logic done;
		slot_t add_slot;
	} token_t;

	// What a cell reports when the token leaves it.
	typedef struct packed {
		logic hit;
		logic [3:0] status;
		logic [3:0] flags;
		logic [15:0] lock;
		logic [31:0] alloc;
		logic eligible;
	} cell_rep_t;
endpackage

@@ design/sht_cell.sv @@
// One slot of the segment handle table; it holds a descriptor and acts on the
// token when the token passes it. Depends on sht_pkg.
`timescale 1ns / 1ps
module sht_cell (
	input logic clk,
	input logic arst_n,
	input logic here,
	input logic in_cap,
	input sht_pkg::token_t tok,
	input logic [31:0] img_len,
	output logic claim,
	output sht_pkg::cell_rep_t rep
);
	import sht_pkg::*;
	slot_t s_q;
	slot_t s_n;
	logic match;
	logic [32:0] fend;

	assign match = in_cap && s_q.hdl == tok.hdl && tok.hdl != 16'd0 && !tok.done;
	assign fend = {1'b0, s_q.foff} + {1'b0, s_q.fsize};

	always_comb begin
		s_n = s_q;
		rep = '0;
		claim = 1'b0;
		if (here && tok.active) begin
			if (tok.op == OP_ADD) begin
				if (in_cap && s_q.hdl == 16'd0 && !tok.done) begin
					claim = 1'b1;
					s_n = tok.add_slot;
					rep.hit = 1'b1;
					rep.flags = tok.add_slot.flags;
					rep.alloc = tok.add_slot.alloc;
				end
			end else if (tok.op == OP_COMPACT) begin
				rep.eligible = in_cap && s_q.hdl != 16'd0 && s_q.flags[1] && s_q.flags[0]
					&& s_q.lock == 16'd0 && s_q.has_data && s_q.alloc != 32'd0;
			end else if (match && tok.op != OP_RESERVED) begin
				claim = 1'b1;
				rep.hit = 1'b1;
				case (tok.op)
					OP_EVICT: begin
						if (!s_q.flags[2]) rep.status = ST_NOT_DISC;
						else if (s_q.lock != 16'd0) rep.status = ST_LOCKED;
						else begin
							s_n.has_data = 1'b0;
							s_n.alloc = '0;
							s_n.flags = {1'b1, s_q.flags[2:1], 1'b0};
						end
					end
					OP_RELOAD: begin
						if (s_q.flags[0]) rep.status = ST_LOADED;
						else if (s_q.fsize != 32'd0 && img_len == 32'd0)
							rep.status = ST_NO_FILE;
						else if (s_q.fsize != 32'd0 && fend > {1'b0, img_len})
							rep.status = ST_BOUNDS;
						else begin
							s_n.alloc = s_q.fsize;
							s_n.has_data = s_q.fsize != 32'd0;
							s_n.flags = {1'b0, s_q.flags[2:1], 1'b1};
						end
					end
					OP_LOCK: begin
						if (!s_q.flags[0]) rep.status = ST_NOT_LOADED;
						else if (s_q.lock != 16'hFFFF) s_n.lock = s_q.lock + 16'd1;
					end
					OP_UNLOCK: begin
						if (s_q.lock != 16'd0) s_n.lock = s_q.lock - 16'd1;
					end
					default: ;
				endcase
				rep.flags = s_n.flags;
				rep.lock = s_n.lock;
				rep.alloc = s_n.alloc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else begin
			s_q <= s_n;
		end
	end
endmodule

@@ design/segment_handle_table.sv @@
// Top level of the segment handle table: a row of slot cells and the token
// sequencer that walks them. Depends on sht_pkg and sht_cell.
`timescale 1ns / 1ps
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_data (in_beat_t)
//  out     | output    | out_valid/out_ready| out_data (out_beat_t)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// The token walks the row slot by slot, and the result is then registered
// in the output register; in_ready returns in the same cycle as the result
// beat. The walk over every slot sets how long an operation occupies the table.
// Reset clears every slot descriptor; no clearing pass.
// A result that has not been taken only holds the next operation at its last
// step, until out_ready frees the output register.
module segment_handle_table #(
	parameter int ENTRIES = sht_pkg::DEFAULT_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sht_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output sht_pkg::out_beat_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import sht_pkg::*;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = $clog2(ENTRIES + 1);

	logic [4:0] cap_q;
	logic [31:0] flen_q;
	logic [15:0] next_q;
	logic [4:0] count_q;
	logic busy_q;
	logic [PW-1:0] pos_q;
	token_t tok_q;
	logic [3:0] status_q;
	logic [3:0] flags_q;
	logic [15:0] lock_q;
	logic [31:0] alloc_q;
	logic [4:0] elig_q;
	logic hit_q;
	logic outv_q;
	out_beat_t out_q;

	logic [ENTRIES-1:0] claim;
	cell_rep_t rep [ENTRIES];
	cell_rep_t cur;
	logic [8:0] cap_eff;
	logic cur_claim;
	logic finish;
	out_beat_t res;

	// Capacity values above the built depth act as the built depth.
	assign cap_eff = (int'(cap_q) > ENTRIES) ? 9'(ENTRIES) : {4'b0, cap_q};

	// Each cell is visited when the walk position reaches its index; the
	// token state (done flag) is handed on to the next cell's visit.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		sht_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.here(busy_q && pos_q == PW'(g)),
			.in_cap(9'(g) < cap_eff),
			.tok(tok_q), .img_len(flen_q),
			.claim(claim[g]), .rep(rep[g])
		);
	end

	assign cur = (pos_q < PW'(ENTRIES)) ? rep[pos_q[IW-1:0]] : '0;
	assign cur_claim = (pos_q < PW'(ENTRIES)) ? claim[pos_q[IW-1:0]] : 1'b0;
	assign in_ready = !busy_q;
	assign out_valid = outv_q;
	assign out_data = out_q;

	// The walk is over; the result may move into the output register once
	// that register is empty or is being emptied in this cycle.
	assign finish = busy_q && pos_q == PW'(ENTRIES) && (!outv_q || out_ready);

	// Result beat built from what the walk collected.
	always_comb begin
		res = '0;
		res.handle_out = tok_q.hdl;
		res.state_flags = flags_q;
		res.lock_count_out = lock_q;
		res.alloc_size_out = alloc_q;
		res.eligible_count = (tok_q.op == OP_COMPACT) ? elig_q : 5'd0;
		if (tok_q.op == OP_ADD) begin
			if (hit_q) begin
				res.status = ST_OK;
				res.handle_out = next_q;
			end else begin
				res.status = ST_FULL;
				res.handle_out = '0;
			end
		end else if (tok_q.op == OP_COMPACT || tok_q.op == OP_RESERVED) begin
			res.status = ST_OK;
		end else if (tok_q.hdl == 16'd0) begin
			res.status = ST_BAD_HANDLE;
		end else if (!hit_q) begin
			res.status = ST_NOT_FOUND;
		end else begin
			res.status = status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
			flen_q <= '0;
			next_q <= 16'd1;
			count_q <= '0;
			busy_q <= 1'b0;
			pos_q <= '0;
			tok_q <= '0;
			outv_q <= 1'b0;
			out_q <= '0;
			hit_q <= 1'b0;
			status_q <= '0;
			flags_q <= '0;
			lock_q <= '0;
			alloc_q <= '0;
			elig_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_CAPACITY) cap_q <= cfg_data[4:0];
			if (cfg_we && cfg_index == REG_FILE_LEN) flen_q <= cfg_data;
			if (finish) outv_q <= 1'b1;
			else if (outv_q && out_ready) outv_q <= 1'b0;
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				pos_q <= '0;
				hit_q <= 1'b0;
				elig_q <= '0;
				flags_q <= '0;
				lock_q <= '0;
				alloc_q <= '0;
				tok_q.active <= 1'b1;
				tok_q.op <= in_data.operation;
				tok_q.hdl <= in_data.handle;
				tok_q.in_cap <= 1'b1;
				// An add with the count at capacity finds no slot at all.
				tok_q.done <= in_data.operation == OP_ADD && {4'b0, count_q} >= cap_eff;
				tok_q.add_slot.hdl <= next_q;
				tok_q.add_slot.flags <= {1'b0, (in_data.seg_flags & NE_DISC) != 16'd0,
					(in_data.seg_flags & NE_MOVABLE) != 16'd0, 1'b1};
				tok_q.add_slot.has_data <= in_data.data_present;
				tok_q.add_slot.lock <= '0;
				tok_q.add_slot.alloc <= in_data.seg_alloc;
				tok_q.add_slot.foff <= in_data.file_offset;
				tok_q.add_slot.fsize <= in_data.file_bytes;
			end else if (busy_q) begin
				if (pos_q < PW'(ENTRIES)) begin
					pos_q <= pos_q + PW'(1);
					elig_q <= elig_q + 5'(cur.eligible);
					if (cur_claim) begin
						tok_q.done <= 1'b1;
						hit_q <= 1'b1;
						status_q <= cur.status;
						flags_q <= cur.flags;
						lock_q <= cur.lock;
						alloc_q <= cur.alloc;
					end
				end else if (finish) begin
					busy_q <= 1'b0;
					tok_q.active <= 1'b0;
					out_q <= res;
					if (tok_q.op == OP_ADD && hit_q) begin
						next_q <= (next_q == 16'hFFFF) ? 16'd1 : next_q + 16'd1;
						count_q <= count_q + 5'd1;
					end
				end
			end
		end
	end
endmodule

@@ design/sht_checker.sv @@
// Port-level checker for the segment handle table, bound to the top level.
// Depends on sht_pkg.
`timescale 1ns / 1ps
module sht_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input sht_pkg::out_beat_t out_data
);
	import sht_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while an operation walks the row");
	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after accept");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_NOT_LOADED)
		else $error("status code out of range");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.handle_out == 16'd0)
		else $error("full status with nonzero handle");
endmodule

bind segment_handle_table sht_checker u_sht_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
